// ----- design/lrrp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and address helpers for the log region ring pointers.
// No dependencies; imported by every module of the block.
package lrrp_pkg;

   // Flash layout
   localparam int HEADER_BYTES       = 256;
   localparam int EVENT_REGION_BYTES = 4096;
   localparam int EXP_REGION_BYTES   = 8192;
   localparam int EVENT_CHUNK_BYTES  = 256;
   localparam int EXP_CHUNK_BYTES    = 512;
   localparam int PAGE_BYTES         = 256;

   localparam int NUM_REGIONS = 6;
   localparam int ADDR_W      = 16;
   localparam int REGION_W    = 3;
   localparam int OP_W        = 2;

   // Region numbers with a meaning of their own
   localparam logic [REGION_W-1:0] REGION_EVENT   = REGION_W'(0);
   localparam logic [REGION_W-1:0] REGION_EXP_MIN = REGION_W'(1);
   localparam logic [REGION_W-1:0] REGION_EXP_MAX = REGION_W'(NUM_REGIONS - 1);
   localparam logic [REGION_W-1:0] REGION_LAST    = REGION_W'(NUM_REGIONS - 1);

   // Region start addresses
   localparam int EXP_BASE = HEADER_BYTES + EVENT_REGION_BYTES;
   localparam logic [ADDR_W-1:0] START_EVENT = ADDR_W'(HEADER_BYTES);
   localparam logic [ADDR_W-1:0] START_EXP1  = ADDR_W'(EXP_BASE);
   localparam logic [ADDR_W-1:0] START_EXP2  = ADDR_W'(EXP_BASE + EXP_REGION_BYTES);
   localparam logic [ADDR_W-1:0] START_EXP3  = ADDR_W'(EXP_BASE + 2 * EXP_REGION_BYTES);
   localparam logic [ADDR_W-1:0] START_EXP4  = ADDR_W'(EXP_BASE + 3 * EXP_REGION_BYTES);
   localparam logic [ADDR_W-1:0] START_EXP5  = ADDR_W'(EXP_BASE + 4 * EXP_REGION_BYTES);

   localparam logic [ADDR_W-1:0] SIZE_EVENT = ADDR_W'(EVENT_REGION_BYTES);
   localparam logic [ADDR_W-1:0] SIZE_EXP   = ADDR_W'(EXP_REGION_BYTES);

   // Increments pre-reduced modulo their region, so one subtract wraps them
   localparam logic [ADDR_W-1:0] STEP_EVENT_CHUNK = ADDR_W'(EVENT_CHUNK_BYTES % EVENT_REGION_BYTES);
   localparam logic [ADDR_W-1:0] STEP_EXP_CHUNK   = ADDR_W'(EXP_CHUNK_BYTES % EXP_REGION_BYTES);
   localparam logic [ADDR_W-1:0] STEP_EVENT_PAGE  = ADDR_W'(PAGE_BYTES % EVENT_REGION_BYTES);
   localparam logic [ADDR_W-1:0] STEP_EXP_PAGE    = ADDR_W'(PAGE_BYTES % EXP_REGION_BYTES);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_EVENT   = 2'd0,
      OP_PUSH_EXP     = 2'd1,
      OP_FETCH_OLDEST = 2'd2
   } op_type;

   // Op code with no meaning to the block: no result, no state change
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Registered request handed from the input stage to the pointer stage
   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [REGION_W-1:0] region;
   } req_type;

   function automatic logic [ADDR_W-1:0] region_start(input logic [REGION_W-1:0] r);
      logic [ADDR_W-1:0] s;
      case (r)
         3'd0:    s = START_EVENT;
         3'd1:    s = START_EXP1;
         3'd2:    s = START_EXP2;
         3'd3:    s = START_EXP3;
         3'd4:    s = START_EXP4;
         3'd5:    s = START_EXP5;
         default: s = START_EVENT;
      endcase
      return s;
   endfunction

   function automatic logic [ADDR_W-1:0] region_size(input logic [REGION_W-1:0] r);
      return (r == REGION_EVENT) ? SIZE_EVENT : SIZE_EXP;
   endfunction

endpackage

// ----- design/lrrp_req_reg.sv -----
`timescale 1ns / 1ps
// Input register: checks and captures one request word per cycle.
// Depends on lrrp_pkg.
module lrrp_req_reg
   import lrrp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [OP_W-1:0]     req_op,
   input  logic [REGION_W-1:0] req_exp_region,
   output req_type             req
);

   logic                valid_ff, valid_in;
   op_type              op_ff, op_in;
   logic [REGION_W-1:0] region_ff, region_in;

   // Decode; unused op codes and bad experiment regions are dropped here
   always_comb begin
      valid_in  = 1'b0;
      op_in     = OP_PUSH_EVENT;
      region_in = REGION_EVENT;
      case (req_op)
         OP_PUSH_EVENT: begin
            valid_in = accept;
         end
         OP_PUSH_EXP: begin
            op_in     = OP_PUSH_EXP;
            region_in = req_exp_region;
            valid_in  = accept && (req_exp_region >= REGION_EXP_MIN)
                               && (req_exp_region <= REGION_EXP_MAX);
         end
         OP_FETCH_OLDEST: begin
            op_in    = OP_FETCH_OLDEST;
            valid_in = accept;
         end
         default: begin
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      region_ff <= region_in;
   end

   assign req.valid  = valid_ff;
   assign req.op     = op_ff;
   assign req.region = region_ff;

endmodule

// ----- design/lrrp_ptr_file.sv -----
`timescale 1ns / 1ps
// Pointer stage: write and oldest pointers, round-robin fetch pointer,
// ring advance and the result register. Depends on lrrp_pkg.
module lrrp_ptr_file
   import lrrp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  req_type             req,
   output logic                rsp_valid,
   output logic [ADDR_W-1:0]   rsp_flash_addr,
   output logic [REGION_W-1:0] rsp_region_kind
);

   logic [ADDR_W-1:0]   write_ff  [NUM_REGIONS];
   logic [ADDR_W-1:0]   oldest_ff [NUM_REGIONS];
   logic [REGION_W-1:0] rr_ff, rr_in;

   logic                fetch;
   logic [REGION_W-1:0] region;
   logic [ADDR_W-1:0]   addr, start, size, step, offset, next_ptr;
   logic [ADDR_W:0]     sum, wrapped;

   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [REGION_W-1:0] rsp_kind_ff;

   // Pick the region and its current pointer
   always_comb begin
      fetch  = (req.op == OP_FETCH_OLDEST);
      region = fetch ? rr_ff : req.region;
      addr   = fetch ? oldest_ff[region] : write_ff[region];
      start  = region_start(region);
      size   = region_size(region);
      case (req.op)
         OP_PUSH_EVENT:   step = STEP_EVENT_CHUNK;
         OP_PUSH_EXP:     step = STEP_EXP_CHUNK;
         OP_FETCH_OLDEST: step = (region == REGION_EVENT) ? STEP_EVENT_PAGE : STEP_EXP_PAGE;
         default:         step = '0;
      endcase
   end

   // Ring advance: offset plus step, one conditional subtract
   always_comb begin
      offset   = addr - start;
      sum      = {1'b0, offset} + {1'b0, step};
      wrapped  = (sum >= {1'b0, size}) ? (sum - {1'b0, size}) : sum;
      next_ptr = start + wrapped[ADDR_W-1:0];
      rr_in    = (rr_ff == REGION_LAST) ? REGION_EVENT : rr_ff + REGION_W'(1);
   end

   // Pointer state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGIONS; i++) begin
            write_ff[i]  <= region_start(REGION_W'(i));
            oldest_ff[i] <= region_start(REGION_W'(i));
         end
         rr_ff <= REGION_EVENT;
      end else if (req.valid) begin
         if (fetch) begin
            oldest_ff[region] <= next_ptr;
            rr_ff             <= rr_in;
         end else begin
            write_ff[region] <= next_ptr;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff <= addr;
      rsp_kind_ff <= region;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_flash_addr  = rsp_addr_ff;
   assign rsp_region_kind = rsp_kind_ff;

endmodule

// ----- design/log_region_ring_pointers.sv -----
`timescale 1ns / 1ps
// Ring pointer manager for a flash log area: one event region and five
// experiment regions after the header. A request is taken at any clock edge
// with start high and busy low, one per cycle; busy is high only in reset and
// the cycle after it. The result (chunk or oldest page address and the region
// served) passes the input register and then the pointer update and result
// register, and appears for one cycle with rsp_valid high. The receiver cannot
// stall. Unused op codes and bad experiment regions give no result. Chunks
// never run past the end of their region.
// Depends on lrrp_pkg, lrrp_req_reg, lrrp_ptr_file.
module log_region_ring_pointers
   import lrrp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_op,
   input  logic [REGION_W-1:0] req_exp_region,
   output logic                rsp_valid,
   output logic [ADDR_W-1:0]   rsp_flash_addr,
   output logic [REGION_W-1:0] rsp_region_kind
);

   logic    busy_ff;
   logic    accept;
   req_type req;

   // Hold requests off while coming out of reset
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   lrrp_req_reg u_req_reg (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_op         (req_op),
      .req_exp_region (req_exp_region),
      .req            (req)
   );

   lrrp_ptr_file u_ptr_file (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .rsp_valid       (rsp_valid),
      .rsp_flash_addr  (rsp_flash_addr),
      .rsp_region_kind (rsp_region_kind)
   );

endmodule

// ----- design/lrrp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for log_region_ring_pointers, bound to the top level.
// Depends on lrrp_pkg.
module lrrp_checker
   import lrrp_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [OP_W-1:0]     req_op,
   input logic [REGION_W-1:0] req_exp_region,
   input logic                rsp_valid,
   input logic [ADDR_W-1:0]   rsp_flash_addr,
   input logic [REGION_W-1:0] rsp_region_kind
);

   // A result word always comes from a request that was taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a request");

   // An event push is answered from the event region
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_PUSH_EVENT) |->
         ##2 (rsp_valid && rsp_region_kind == REGION_EVENT))
      else $error("event push not answered");

   // An experiment push is answered from the region asked for
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_PUSH_EXP && req_exp_region >= REGION_EXP_MIN
         && req_exp_region <= REGION_EXP_MAX) |->
         ##2 (rsp_valid && rsp_region_kind == $past(req_exp_region, 2)))
      else $error("experiment push answered from wrong region");

   // Unused op codes give no result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_UNUSED) |-> ##2 !rsp_valid)
      else $error("result for unused op code");

   // Event region addresses stay inside the event region
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_region_kind == REGION_EVENT) |->
         (rsp_flash_addr >= START_EVENT && rsp_flash_addr < START_EXP1))
      else $error("event address outside its region");

endmodule

bind log_region_ring_pointers lrrp_checker u_lrrp_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_op          (req_op),
   .req_exp_region  (req_exp_region),
   .rsp_valid       (rsp_valid),
   .rsp_flash_addr  (rsp_flash_addr),
   .rsp_region_kind (rsp_region_kind)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for log_region_ring_pointers: drives push and fetch words,
// predicts each region's write and oldest pointers and checks every returned address.
// Depends on lrrp_pkg and the log_region_ring_pointers top level.
module testbench;
   import lrrp_pkg::*;

   localparam int              CYCLE_LIMIT = 100000;
   localparam int              DRAIN_WAIT  = 4;
   localparam int              PHASE_WORDS = 316;

   // Pointer predictor and store of addresses still due from the block
   class log_slot_tracker;
      typedef struct {
         logic [ADDR_W-1:0]   addr;
         logic [REGION_W-1:0] region;
      } log_slot;

      logic [ADDR_W-1:0] wr_ptr  [NUM_REGIONS];
      logic [ADDR_W-1:0] old_ptr [NUM_REGIONS];
      int unsigned       read_turn;
      log_slot           due_slots[$];
      int                errors, matched, pushes, fetches, ignored;

      function new();
         for (int r = 0; r < NUM_REGIONS; r++) begin
            wr_ptr[r]  = ADDR_W'(base_of(r));
            old_ptr[r] = ADDR_W'(base_of(r));
         end
         read_turn = 0;
         errors = 0; matched = 0; pushes = 0; fetches = 0; ignored = 0;
      endfunction

      function int unsigned base_of(int unsigned r);
         if (r == 0) return HEADER_BYTES;
         return HEADER_BYTES + EVENT_REGION_BYTES + (r - 1) * EXP_REGION_BYTES;
      endfunction

      function int unsigned span_of(int unsigned r);
         return (r == 0) ? EVENT_REGION_BYTES : EXP_REGION_BYTES;
      endfunction

      // Wrap inside the region with one subtract of a pre-reduced increment
      function logic [ADDR_W-1:0] advance(int unsigned r, logic [ADDR_W-1:0] ptr,
                                          int unsigned incr);
         int unsigned offs, stride, total;
         offs   = (ptr - base_of(r)) % span_of(r);
         stride = incr % span_of(r);
         total  = offs + stride;
         if (total >= span_of(r)) total -= span_of(r);
         return ADDR_W'(base_of(r) + total);
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [REGION_W-1:0] er);
         log_slot     s;
         int unsigned r;
         if (op == OP_PUSH_EVENT) begin
            r = REGION_EVENT;
            s.addr = wr_ptr[r];
            wr_ptr[r] = advance(r, wr_ptr[r], EVENT_CHUNK_BYTES);
            pushes++;
         end else if (op == OP_PUSH_EXP && er >= REGION_EXP_MIN && er <= REGION_EXP_MAX) begin
            r = er;
            s.addr = wr_ptr[r];
            wr_ptr[r] = advance(r, wr_ptr[r], EXP_CHUNK_BYTES);
            pushes++;
         end else if (op == OP_FETCH_OLDEST) begin
            r = read_turn;
            s.addr = old_ptr[r];
            old_ptr[r] = advance(r, old_ptr[r], PAGE_BYTES);
            read_turn = (r == REGION_LAST) ? 0 : r + 1;
            fetches++;
         end else begin
            // unused op or bad experiment region: nothing comes back
            ignored++;
            return;
         end
         s.region = REGION_W'(r);
         due_slots.push_back(s);
      endfunction

      function void check_slot(logic [ADDR_W-1:0] addr, logic [REGION_W-1:0] region);
         log_slot s;
         if (due_slots.size() == 0) begin
            $display("%0t: unexpected result, address %h region %0d", $time, addr, region);
            errors++;
            return;
         end
         s = due_slots.pop_front();
         if (addr !== s.addr) begin
            $display("%0t: flash address mismatch: expected %h, got %h", $time, s.addr, addr);
            errors++;
         end
         if (region !== s.region) begin
            $display("%0t: region mismatch: expected %0d, got %0d", $time, s.region, region);
            errors++;
         end
         if (addr === s.addr && region === s.region) matched++;
      endfunction

      function int pending();
         return due_slots.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_op;
   logic [REGION_W-1:0] req_exp_region;
   logic                rsp_valid;
   logic [ADDR_W-1:0]   rsp_flash_addr;
   logic [REGION_W-1:0] rsp_region_kind;

   log_slot_tracker slots = new();
   int              cycles = 0;

   log_region_ring_pointers dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_exp_region  (req_exp_region),
      .rsp_valid       (rsp_valid),
      .rsp_flash_addr  (rsp_flash_addr),
      .rsp_region_kind (rsp_region_kind)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watch both channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) slots.note_request(req_op, req_exp_region);
         if (rsp_valid) slots.check_slot(rsp_flash_addr, rsp_region_kind);
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Offer one word after a random gap, hold it until taken
   task automatic send_word(input logic [OP_W-1:0] op, input logic [REGION_W-1:0] er,
                            input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_op         <= op;
      req_exp_region <= er;
      do @(posedge clock); while (busy);
   endtask

   // Stop sending until every due result is back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (slots.pending() != 0) @(posedge clock);
   endtask

   // Mostly valid pushes and fetches, some bad regions and unused ops
   task automatic send_random(input int idle_pct);
      int unsigned        sel, pick;
      logic [OP_W-1:0]     op;
      logic [REGION_W-1:0] er;
      sel = $urandom_range(99);
      er  = REGION_W'($urandom_range(7));
      if (sel < 28) begin
         op = OP_PUSH_EVENT;
      end else if (sel < 63) begin
         op = OP_PUSH_EXP;
         if ($urandom_range(9) == 0) begin
            pick = $urandom_range(2);
            er   = (pick == 0) ? REGION_EVENT : REGION_W'(REGION_EXP_MAX + pick);
         end else begin
            er = REGION_W'($urandom_range(REGION_EXP_MAX, REGION_EXP_MIN));
         end
      end else if (sel < 95) begin
         op = OP_FETCH_OLDEST;
      end else begin
         op = OP_UNUSED;
      end
      send_word(op, er, idle_pct);
   endtask

   initial begin
      int phase_idle [3];
      phase_idle     = '{0, 53, 37};
      reset          <= 1'b1;
      start          <= 1'b0;
      req_op         <= OP_PUSH_EVENT;
      req_exp_region <= REGION_EVENT;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every op, bad regions, a full fetch round
      send_word(OP_PUSH_EVENT, REGION_EVENT, 0);
      send_word(OP_PUSH_EVENT, 3'd7, 0);
      for (int r = REGION_EXP_MIN; r <= REGION_EXP_MAX; r++)
         send_word(OP_PUSH_EXP, REGION_W'(r), 0);
      send_word(OP_PUSH_EXP, REGION_EVENT, 0);
      send_word(OP_PUSH_EXP, 3'd6, 0);
      send_word(OP_PUSH_EXP, 3'd7, 0);
      send_word(OP_UNUSED, REGION_EVENT, 0);
      send_word(OP_UNUSED, 3'd7, 0);
      for (int i = 0; i <= NUM_REGIONS; i++)
         send_word(OP_FETCH_OLDEST, REGION_W'(i), 0);
      send_word(OP_PUSH_EVENT, 3'd3, 0);
      drain();

      // Random phases, each ending with a full drain
      foreach (phase_idle[p]) begin
         for (int i = 0; i < PHASE_WORDS; i++) send_random(phase_idle[p]);
         drain();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (slots.pending() != 0) begin
         $display("%0t: %0d results never arrived", $time, slots.pending());
         slots.errors += slots.pending();
      end
      $display("Covered %0d pushes and %0d round-robin fetches, %0d words ignored by the block;",
               slots.pushes, slots.fetches, slots.ignored);
      $display("%0d results matched, %0d errors, over idle rates of 0, 53 and 37 percent.",
               slots.matched, slots.errors);
      if (slots.errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ----- sim.f -----
design/lrrp_pkg.sv
design/lrrp_req_reg.sv
design/lrrp_ptr_file.sv
design/log_region_ring_pointers.sv
design/lrrp_checker.sv
verif/testbench.sv
